>>> design/pfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the page frame allocator: frame bitmap
// sizing, directory entry layout, command codes and controller commands.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int NUM_FRAMES = 32;
  localparam int DIR_DEPTH  = 1024;

  localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
  localparam int SLOT_W  = $clog2(DIR_DEPTH);
  localparam int PFN_W   = 10;
  localparam int CMP_W   = 11;

  localparam int SLOT_LSB   = 22;
  localparam int NEED_LSB   = 22;
  localparam logic [SLOT_W-1:0] LOW_SLOT  = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] HIGH_SLOT = SLOT_W'('h300);

  typedef enum logic [1:0] {
    CMD_CHECK = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } pfa_cmd_e;

  typedef struct packed {
    logic [PFN_W-1:0] frame;
    logic             huge_page;
    logic             user;
    logic             writable;
    logic             present;
  } pfa_entry_t;

  localparam pfa_entry_t RESET_ENTRY = '{
    frame: '0, huge_page: 1'b1, user: 1'b0, writable: 1'b1, present: 1'b1
  };

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] virtual_address;
    logic [31:0] request_bytes;
  } pfa_req_t;

  typedef struct packed {
    logic             ok;
    logic [PFN_W-1:0] frame_number;
    logic [9:0]       directory_slot;
    logic             flush_tlb;
  } pfa_rsp_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_LOAD  = 2'd2,
    OP_EXEC  = 2'd3
  } pfa_op_e;

  typedef struct packed {
    pfa_op_e           op;
    logic [SLOT_W-1:0] clr_addr;
  } pfa_ctrl_t;

endpackage

>>> design/pfa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer: sweeps the directory after reset, then takes one command beat
// and runs it through a load cycle and an execute cycle.
// ----------------------------------------------------------------------------
module pfa_ctrl
  import pfa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output pfa_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] clr_q, clr_d;
  logic              busy_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    ctrl_o.op    = OP_NONE;
    ctrl_o.clr_addr = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        ctrl_o.op = OP_CLEAR;
        clr_d     = clr_q + SLOT_W'(1);
        if (clr_q == {SLOT_W{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.op = OP_LOAD;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl_o.op = OP_EXEC;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

>>> design/pfa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_datapath
// Frame bitmap, free counter, lowest-free search and the page directory
// memory with its read-modify-write path and the result register.
// ----------------------------------------------------------------------------
module pfa_datapath
  import pfa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pfa_ctrl_t ctrl_i,
  input  pfa_req_t  req_i,
  output pfa_rsp_t  rsp_o,
  output logic      done_o
);

  pfa_entry_t dir_mem [DIR_DEPTH];

  logic [NUM_FRAMES-1:0]  used_q, used_d;
  logic [CNT_W-1:0]       free_cnt_q, free_cnt_d;
  logic [FRAME_W-1:0]     ff_q, ff_d;
  pfa_req_t               req_q;
  pfa_entry_t             rd_q;
  pfa_rsp_t               rsp_q, rsp_d;
  logic                   done_q;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  pfa_entry_t        mem_wdata;
  logic [SLOT_W-1:0] slot;
  logic [9:0]        need;
  logic              frame_in_range;

  // lowest free frame, registered; the bitmap has settled before ff_q is used
  always_comb begin
    ff_d = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        ff_d = FRAME_W'(i);
      end
    end
  end

  assign slot           = req_q.virtual_address[SLOT_LSB +: SLOT_W];
  assign frame_in_range = ({1'b0, rd_q.frame} < CMP_W'(NUM_FRAMES));

  always_comb begin
    need = req_q.request_bytes[NEED_LSB +: 10];
    if (need == '0) begin
      need = 10'd1;
    end
  end

  always_comb begin
    used_d     = used_q;
    free_cnt_d = free_cnt_q;
    rsp_d      = '0;
    mem_we     = 1'b0;
    mem_waddr  = slot;
    mem_wdata  = rd_q;
    if (ctrl_i.op == OP_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = ctrl_i.clr_addr;
      mem_wdata = (ctrl_i.clr_addr == LOW_SLOT || ctrl_i.clr_addr == HIGH_SLOT) ?
                  RESET_ENTRY : '0;
    end else if (ctrl_i.op == OP_EXEC) begin
      unique case (pfa_cmd_e'(req_q.command))
        CMD_CHECK: begin
          rsp_d.ok = (CMP_W'(free_cnt_q) >= CMP_W'(need));
        end
        CMD_ALLOC: begin
          rsp_d.directory_slot = 10'(slot);
          if (free_cnt_q != '0) begin
            rsp_d.ok           = 1'b1;
            rsp_d.frame_number = PFN_W'(ff_q);
            rsp_d.flush_tlb    = 1'b1;
            used_d[ff_q]       = 1'b1;
            free_cnt_d         = free_cnt_q - CNT_W'(1);
            mem_we             = 1'b1;
            mem_wdata          = '{frame: PFN_W'(ff_q), huge_page: 1'b1, user: 1'b1,
                                   writable: 1'b1, present: 1'b1};
          end
        end
        CMD_FREE: begin
          rsp_d.directory_slot = 10'(slot);
          if (rd_q.present) begin
            rsp_d.ok           = 1'b1;
            rsp_d.frame_number = rd_q.frame;
            mem_we             = 1'b1;
            mem_wdata.present  = 1'b0;
            // only count a frame back if it was actually marked used
            if (frame_in_range && used_q[rd_q.frame[FRAME_W-1:0]]) begin
              used_d[rd_q.frame[FRAME_W-1:0]] = 1'b0;
              free_cnt_d = free_cnt_q + CNT_W'(1);
            end
          end
        end
        default: begin
          rsp_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= NUM_FRAMES'(1);
      free_cnt_q <= CNT_W'(NUM_FRAMES - 1);
      ff_q       <= FRAME_W'(1);
      done_q     <= 1'b0;
    end else begin
      used_q     <= used_d;
      free_cnt_q <= free_cnt_d;
      ff_q       <= ff_d;
      done_q     <= (ctrl_i.op == OP_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_LOAD) begin
      req_q <= req_i;
      rd_q  <= dir_mem[req_i.virtual_address[SLOT_LSB +: SLOT_W]];
    end
    if (mem_we) begin
      dir_mem[mem_waddr] <= mem_wdata;
    end
    rsp_q <= rsp_d;
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

>>> design/page_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator
// Each command beat is accepted when start_i is high and busy_o is low; its
// result is on rsp_o for one cycle, marked by done_o, after its load and execute steps.
// A new command is taken only once the last has executed: a directory read step
// then an execute/write step on the single-port directory memory. The receiver cannot stall.
// After reset busy_o stays high while the directory is swept.
// ----------------------------------------------------------------------------
module page_frame_allocator
  import pfa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  pfa_req_t req_i,
  output pfa_rsp_t rsp_o,
  output logic     done_o
);

  pfa_ctrl_t ctrl;

  pfa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .ctrl_o  (ctrl)
  );

  pfa_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .done_o (done_o)
  );

endmodule
